FILE: hw/rtl/srt_pkg.sv
// Shared types, widths and codes for the sorted record table.
`timescale 1ns / 1ps
package srt_pkg;

  // Number of record cells in the row.
  localparam int DEPTH = 16;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 16;
  localparam int POS_W    = 4;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int PICK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int ECNT_W   = 5;

  // Width of the internal record counter, which must hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Number of cells that the position field can reach.
  localparam int READ_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTYPOS = 2'd3;

  // One stored record.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [PICK_W-1:0]  pick_a;
    logic [PICK_W-1:0]  pick_b;
    logic [PICK_W-1:0]  pick_c;
    logic [PICK_W-1:0]  pick_d;
    logic [PICK_W-1:0]  pick_e;
    logic [PICK_W-1:0]  pick_f;
  } rec_t;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/srt_if.sv
// Handshake channels for operation beats and result beats.
`timescale 1ns / 1ps
interface srt_in_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [POS_W-1:0]   position;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [PICK_W-1:0]  pick_a;
  logic [PICK_W-1:0]  pick_b;
  logic [PICK_W-1:0]  pick_c;
  logic [PICK_W-1:0]  pick_d;
  logic [PICK_W-1:0]  pick_e;
  logic [PICK_W-1:0]  pick_f;

  modport source (
    output valid, kind, key, position, year, month, day,
    output pick_a, pick_b, pick_c, pick_d, pick_e, pick_f,
    input  ready
  );
  modport sink (
    input  valid, kind, key, position, year, month, day,
    input  pick_a, pick_b, pick_c, pick_d, pick_e, pick_f,
    output ready
  );
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECNT_W-1:0]   entry_count;
  logic [KEY_W-1:0]    out_key;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [PICK_W-1:0]   out_pick_a;
  logic [PICK_W-1:0]   out_pick_b;
  logic [PICK_W-1:0]   out_pick_c;
  logic [PICK_W-1:0]   out_pick_d;
  logic [PICK_W-1:0]   out_pick_e;
  logic [PICK_W-1:0]   out_pick_f;

  modport source (
    output valid, status, entry_count, out_key, out_year, out_month, out_day,
    output out_pick_a, out_pick_b, out_pick_c, out_pick_d, out_pick_e, out_pick_f,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, out_key, out_year, out_month, out_day,
    input  out_pick_a, out_pick_b, out_pick_c, out_pick_d, out_pick_e, out_pick_f,
    output ready
  );
endinterface

FILE: hw/rtl/srt_cell.sv
// One record cell of the sorted row: compares its key and shifts with its neighbors.
`timescale 1ns / 1ps
module srt_cell import srt_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  rec_t      new_rec,
  input  logic      occupied,
  input  logic      left_ge,
  input  rec_t      left_rec,
  input  rec_t      right_rec,
  output logic      ge,
  output logic      match,
  output rec_t      rec
);

  // An empty cell counts as greater, so the insert point is the first cell
  // that raises this flag while its left neighbor does not.
  assign ge    = !occupied || (rec.key >= new_rec.key);
  assign match = occupied && (rec.key == new_rec.key);

  // Insert opens a gap at the first greater-or-equal cell and pushes the rest
  // right; delete pulls every cell from the first match onward to the left.
  always_ff @(posedge clk) begin
    if (ctl.ins && ge) begin
      rec <= left_ge ? left_rec : new_rec;
    end else if (ctl.del && ge) begin
      rec <= right_rec;
    end
  end

endmodule

FILE: hw/rtl/sorted_record_table.sv
// Top level of the sorted record table: a row of shifting record cells and a result register.
`timescale 1ns / 1ps
// The table keeps up to DEPTH records in ascending key order in a row of cells
// that all compare their keys against the incoming key at once, so an insert,
// delete or read finishes in the cycle it is accepted. The result beat
// appears in the next cycle from the output register; a new operation is
// accepted whenever that register is empty or is being drained in the same
// cycle, so the rate is one beat per cycle unless the result side stalls. An
// insert goes in front of any equal keys; a delete removes the first equal
// key. Every result carries the record count after the operation. No clearing
// pass is needed after reset.
module sorted_record_table import srt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  srt_in_if.sink    cmd,
  srt_out_if.source res
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             acc;
  logic             is_full;
  logic             found;
  logic             ins_go;
  logic             del_go;
  rec_t             new_rec;
  rec_t             read_rec;
  cell_ctl_t        ctl;
  logic             pos_empty;

  logic [DEPTH-1:0] cell_ge;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] cell_occ;
  rec_t             cell_rec [DEPTH];

  // Result register.
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [ECNT_W-1:0]   res_count;
  rec_t                res_rec;
  logic [STATUS_W-1:0] status_next;
  rec_t                rec_next;

  assign cmd.ready = !res_valid || res.ready;
  assign acc       = cmd.valid && cmd.ready;

  assign new_rec = '{key: cmd.key, year: cmd.year, month: cmd.month, day: cmd.day,
                     pick_a: cmd.pick_a, pick_b: cmd.pick_b, pick_c: cmd.pick_c,
                     pick_d: cmd.pick_d, pick_e: cmd.pick_e, pick_f: cmd.pick_f};

  // Row control: a full table ignores inserts, a missing key ignores deletes.
  assign is_full = (count == CNT_W'(DEPTH));
  assign found   = |cell_match;
  assign ins_go  = acc && (cmd.kind == KIND_INSERT) && !is_full;
  assign del_go  = acc && (cmd.kind == KIND_DELETE) && found;
  assign ctl     = '{ins: ins_go, del: del_go};

  // The cell row, each cell wired to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;
    logic left_ge;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_ge  = 1'b0;
      assign left_rec = new_rec;
    end else begin : g_mid
      assign left_ge  = cell_ge[i-1];
      assign left_rec = cell_rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    srt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_rec   (new_rec),
      .occupied  (cell_occ[i]),
      .left_ge   (left_ge),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .ge        (cell_ge[i]),
      .match     (cell_match[i]),
      .rec       (cell_rec[i])
    );
  end

  // Record count.
  always_comb begin
    count_next = count;
    if (ins_go) begin
      count_next = count + CNT_W'(1);
    end else if (del_go) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Read select over the cells the position field can address.
  assign pos_empty = (32'(cmd.position) >= 32'(count));

  always_comb begin
    read_rec = '0;
    for (int i = 0; i < READ_N; i++) begin
      if (cmd.position == POS_W'(i)) begin
        read_rec = cell_rec[i];
      end
    end
  end

  // Status and record fields of the result.
  always_comb begin
    status_next = ST_DONE;
    rec_next    = '0;
    case (cmd.kind)
      KIND_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end
      end
      KIND_DELETE: begin
        if (!found) begin
          status_next = ST_NOTFOUND;
        end
      end
      KIND_READ: begin
        if (pos_empty) begin
          status_next = ST_EMPTYPOS;
        end else begin
          rec_next = read_rec;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_status <= status_next;
      res_count  <= ECNT_W'(count_next);
      res_rec    <= rec_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.entry_count = res_count;
  assign res.out_key     = res_rec.key;
  assign res.out_year    = res_rec.year;
  assign res.out_month   = res_rec.month;
  assign res.out_day     = res_rec.day;
  assign res.out_pick_a  = res_rec.pick_a;
  assign res.out_pick_b  = res_rec.pick_b;
  assign res.out_pick_c  = res_rec.pick_c;
  assign res.out_pick_d  = res_rec.pick_d;
  assign res.out_pick_e  = res_rec.pick_e;
  assign res.out_pick_f  = res_rec.pick_f;

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("record count above table depth");

  // A successful insert grows the count by one.
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    ins_go |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  // A delete of an absent key leaves the count alone.
  a_del_miss: assert property (@(posedge clk) disable iff (rst)
    acc && (cmd.kind == KIND_DELETE) && !found |=> count == $past(count))
    else $error("failed delete changed the count");

  // A full status is only reported with a full table.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_FULL) |-> res_count == ECNT_W'(DEPTH))
    else $error("full status with a table that is not full");

  // Occupied neighbors stay in ascending key order.
  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_occ[i+1] |-> cell_rec[i].key <= cell_rec[i+1].key)
      else $error("stored keys out of order");
  end

endmodule

FILE: tb/sorted_record_table_checker.sv
// Checker for the sorted record table: predicts each result beat and compares it.
`timescale 1ns / 1ps
module sorted_record_table_checker import srt_pkg::*; (
  input  logic clk,
  input  logic rst,
  srt_in_if    cmd_mon,
  srt_out_if   res_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ECNT_W-1:0]   entry_count;
    rec_t                rec;
  } table_result_t;

  // Shadow copy of the table, kept in ascending key order.
  rec_t          table_rows[DEPTH];
  int unsigned   row_count;
  table_result_t expected_results[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Applies one operation to the shadow table and returns the result it gives.
  function automatic table_result_t predict_table_op(input logic [KIND_W-1:0] kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input rec_t rec);
    table_result_t res;
    int unsigned   slot;
    res = '0;
    res.status = ST_DONE;
    case (kind)
      KIND_INSERT: begin
        if (row_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // The new record goes in front of every stored record with an equal key.
          slot = 0;
          while (slot < row_count && rec.key > table_rows[slot].key) slot++;
          for (int unsigned i = row_count; i > slot; i--) table_rows[i] = table_rows[i - 1];
          table_rows[slot] = rec;
          row_count++;
        end
      end
      KIND_DELETE: begin
        slot = 0;
        while (slot < row_count && table_rows[slot].key != rec.key) slot++;
        if (slot >= row_count) begin
          res.status = ST_NOTFOUND;
        end else begin
          for (int unsigned i = slot; i + 1 < row_count; i++) table_rows[i] = table_rows[i + 1];
          row_count--;
        end
      end
      KIND_READ: begin
        if (pos >= row_count) begin
          res.status = ST_EMPTYPOS;
        end else begin
          res.rec = table_rows[pos];
        end
      end
      default: begin
        // The spare operation code leaves the table alone.
      end
    endcase
    res.entry_count = row_count[ECNT_W-1:0];
    return res;
  endfunction

  task automatic compare_result(input table_result_t got, input table_result_t want);
    check_field("status", got.status, want.status);
    check_field("entry_count", got.entry_count, want.entry_count);
    check_field("out_key", got.rec.key, want.rec.key);
    check_field("out_year", got.rec.year, want.rec.year);
    check_field("out_month", got.rec.month, want.rec.month);
    check_field("out_day", got.rec.day, want.rec.day);
    check_field("out_pick_a", got.rec.pick_a, want.rec.pick_a);
    check_field("out_pick_b", got.rec.pick_b, want.rec.pick_b);
    check_field("out_pick_c", got.rec.pick_c, want.rec.pick_c);
    check_field("out_pick_d", got.rec.pick_d, want.rec.pick_d);
    check_field("out_pick_e", got.rec.pick_e, want.rec.pick_e);
    check_field("out_pick_f", got.rec.pick_f, want.rec.pick_f);
  endtask

  // Result beats are matched before operation beats, since a result never
  // belongs to an operation accepted at the same edge.
  always @(posedge clk) begin
    table_result_t got;
    rec_t          in_rec;
    if (rst) begin
      row_count = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.status       = res_mon.status;
        got.entry_count  = res_mon.entry_count;
        got.rec.key      = res_mon.out_key;
        got.rec.year     = res_mon.out_year;
        got.rec.month    = res_mon.out_month;
        got.rec.day      = res_mon.out_day;
        got.rec.pick_a   = res_mon.out_pick_a;
        got.rec.pick_b   = res_mon.out_pick_b;
        got.rec.pick_c   = res_mon.out_pick_c;
        got.rec.pick_d   = res_mon.out_pick_d;
        got.rec.pick_e   = res_mon.out_pick_e;
        got.rec.pick_f   = res_mon.out_pick_f;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no operation outstanding");
        end else begin
          compare_result(got, expected_results.pop_front());
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        in_rec.key    = cmd_mon.key;
        in_rec.year   = cmd_mon.year;
        in_rec.month  = cmd_mon.month;
        in_rec.day    = cmd_mon.day;
        in_rec.pick_a = cmd_mon.pick_a;
        in_rec.pick_b = cmd_mon.pick_b;
        in_rec.pick_c = cmd_mon.pick_c;
        in_rec.pick_d = cmd_mon.pick_d;
        in_rec.pick_e = cmd_mon.pick_e;
        in_rec.pick_f = cmd_mon.pick_f;
        expected_results.push_back(predict_table_op(cmd_mon.kind, cmd_mon.position, in_rec));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: tb/sorted_record_table_tb.sv
// Testbench top for the sorted record table: clock, reset, operation stimulus and verdict.
`timescale 1ns / 1ps
module sorted_record_table_tb import srt_pkg::*; ();

  // Operation code that the block must treat as a no-op.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_OPS   = 1250;
  localparam int PHASE_LEN    = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   quiet_cycles = 0;
  bit   src_gappy = 1'b0;
  bit   sink_gappy = 1'b0;
  int   sink_phase_left = 0;
  int   sink_stall_left = 0;

  srt_in_if  cmd_ch ();
  srt_out_if res_ch ();

  sorted_record_table u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  sorted_record_table_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_mon       (cmd_ch),
    .res_mon       (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Keys come mostly from a small pool so that deletes find their targets.
  function automatic logic [KEY_W-1:0] random_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return KEY_W'($urandom_range(0, 11));
    end else if (roll < 70) begin
      return ($urandom_range(0, 1) == 0) ? '0 : '1;
    end
    return KEY_W'($urandom);
  endfunction

  // Record contents: mostly legal dates and numbers, sometimes anything the widths allow.
  function automatic rec_t random_rec(input logic [KEY_W-1:0] key);
    rec_t r;
    bit   wild;
    wild     = ($urandom_range(0, 4) == 0);
    r.key    = key;
    r.year   = wild ? YEAR_W'($urandom) : YEAR_W'($urandom_range(0, 9999));
    r.month  = wild ? MONTH_W'($urandom) : MONTH_W'($urandom_range(1, 12));
    r.day    = wild ? DAY_W'($urandom) : DAY_W'($urandom_range(1, 31));
    r.pick_a = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    r.pick_b = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    r.pick_c = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    r.pick_d = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    r.pick_e = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    r.pick_f = wild ? PICK_W'($urandom) : PICK_W'($urandom_range(1, 49));
    return r;
  endfunction

  // Drives one operation beat and holds it until the block takes it.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input rec_t rec);
    int gap;
    gap = (src_gappy && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.kind     <= kind;
    cmd_ch.position <= pos;
    cmd_ch.key      <= rec.key;
    cmd_ch.year     <= rec.year;
    cmd_ch.month    <= rec.month;
    cmd_ch.day      <= rec.day;
    cmd_ch.pick_a   <= rec.pick_a;
    cmd_ch.pick_b   <= rec.pick_b;
    cmd_ch.pick_c   <= rec.pick_c;
    cmd_ch.pick_d   <= rec.pick_d;
    cmd_ch.pick_e   <= rec.pick_e;
    cmd_ch.pick_f   <= rec.pick_f;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Result side: phases of steady acceptance alternate with phases of random stalls.
  always @(negedge clk) begin
    if (sink_phase_left == 0) begin
      sink_phase_left = $urandom_range(50, 300);
      sink_gappy      = ($urandom_range(0, 2) != 0);
    end else begin
      sink_phase_left--;
    end
    if (sink_stall_left > 0) begin
      sink_stall_left--;
      res_ch.ready <= 1'b0;
    end else if (sink_gappy && $urandom_range(0, 3) == 0) begin
      sink_stall_left = idle_len() - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_record_table test failed");
      $finish;
    end
  end

  initial begin : stimulus
    rec_t              r;
    op_mix_e           mix;
    int                roll;
    int                ins_pct;
    int                del_pct;
    logic [KIND_W-1:0] kind;

    mix             = MIX_EVEN;
    ins_pct         = 35;
    del_pct         = 30;
    cmd_ch.valid    = 1'b0;
    cmd_ch.kind     = KIND_INSERT;
    cmd_ch.position = '0;
    cmd_ch.key      = '0;
    cmd_ch.year     = '0;
    cmd_ch.month    = '0;
    cmd_ch.day      = '0;
    cmd_ch.pick_a   = '0;
    cmd_ch.pick_b   = '0;
    cmd_ch.pick_c   = '0;
    cmd_ch.pick_d   = '0;
    cmd_ch.pick_e   = '0;
    cmd_ch.pick_f   = '0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table, field extremes, equal keys, misses and the spare code.
    r = '0;
    send_op(KIND_READ, '0, r);
    send_op(KIND_DELETE, '0, r);
    send_op(KIND_INSERT, '0, r);
    r = '1;
    send_op(KIND_INSERT, '0, r);
    r = random_rec('0);
    r.year  = 14'd9999;
    r.month = 4'd12;
    r.day   = 5'd31;
    send_op(KIND_INSERT, '0, r);
    send_op(KIND_INSERT, '0, random_rec(16'h8000));
    for (int p = 0; p < 4; p++) begin
      send_op(KIND_READ, POS_W'(p), r);
    end
    send_op(KIND_READ, '1, r);
    send_op(KIND_DELETE, '0, random_rec(16'h1234));
    send_op(KIND_DELETE, '0, random_rec('0));
    send_op(KIND_READ, '0, r);
    send_op(KIND_SPARE, '1, random_rec(random_key()));
    send_op(KIND_DELETE, '0, random_rec('1));
    send_op(KIND_READ, POS_W'(1), r);

    // Random part: phases that fill, drain or churn the table.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        mix       = op_mix_e'($urandom_range(0, 2));
        src_gappy = ($urandom_range(0, 2) != 0);
        case (mix)
          MIX_FILL: begin
            ins_pct = 65;
            del_pct = 15;
          end
          MIX_DRAIN: begin
            ins_pct = 15;
            del_pct = 65;
          end
          default: begin
            ins_pct = 35;
            del_pct = 30;
          end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        kind = KIND_INSERT;
      end else if (roll < ins_pct + del_pct) begin
        kind = KIND_DELETE;
      end else if (roll < 95) begin
        kind = KIND_READ;
      end else begin
        kind = KIND_SPARE;
      end
      send_op(kind, POS_W'($urandom), random_rec(random_key()));
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;

    // Let every outstanding result arrive before the verdict.
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("sorted_record_table test passed");
    end else begin
      $display("sorted_record_table test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_if.sv
hw/rtl/srt_cell.sv
hw/rtl/sorted_record_table.sv
tb/sorted_record_table_checker.sv
tb/sorted_record_table_tb.sv
